### hdl/ptpcr_pkg.sv
package ptpcr_pkg;

    // Container header checks.
    localparam int unsigned MAX_PARAMS = 5;
    localparam logic [31:0] HDR_BYTES = 32'd12;
    localparam logic [31:0] MAX_LEN = HDR_BYTES + 32'(4 * MAX_PARAMS);
    localparam logic [31:0] ONE_PARAM_LEN = HDR_BYTES + 32'd4;
    localparam logic [15:0] KIND_COMMAND = 16'h0001;
    localparam logic [15:0] KIND_DATA = 16'h0002;
    localparam logic [15:0] OP_CLASS_MASK = 16'h7000;
    localparam logic [15:0] OP_CLASS_CMD = 16'h1000;

    // Operation codes that the responder serves.
    localparam logic [15:0] OPC_GET_DEVICE_INFO = 16'h1001;
    localparam logic [15:0] OPC_OPEN_SESSION = 16'h1002;
    localparam logic [15:0] OPC_CLOSE_SESSION = 16'h1003;
    localparam logic [15:0] OPC_GET_STORAGE_IDS = 16'h1004;
    localparam logic [15:0] OPC_GET_STORAGE_INFO = 16'h1005;
    localparam logic [15:0] OPC_GET_OBJ_HANDLES = 16'h1007;

    // Reset value of the storage identifier register.
    localparam logic [31:0] STORAGE_ID_RESET = 32'h0001_0001;

    // Operation selector that the front end hands to the back end.
    typedef enum logic [2:0] {
        SEL_DEVICE_INFO,
        SEL_OPEN,
        SEL_CLOSE,
        SEL_STORAGE_IDS,
        SEL_STORAGE_INFO,
        SEL_OBJ_HANDLES,
        SEL_OTHER
    } op_sel_t;

    // Response status codes.
    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_GENERAL = 3'd1;
    localparam logic [2:0] ST_NO_SESSION = 3'd2;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd3;
    localparam logic [2:0] ST_BAD_STORAGE = 3'd4;
    localparam logic [2:0] ST_BAD_PARAM = 3'd5;
    localparam logic [2:0] ST_ALREADY_OPEN = 3'd6;

    // Command queue between front and back end.
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    // Output word layout.
    localparam int unsigned IN_TDATA_W = 112;
    localparam int unsigned OUT_TDATA_W = 56;
    localparam int unsigned OUT_TID_LSB = 19;

    // One classified command as it sits in the queue.
    typedef struct packed {
        logic        fmt_ok;
        op_sel_t     op_sel;
        logic        np_zero;
        logic        np_one;
        logic [31:0] tid;
        logic [31:0] p0;
    } cmd_t;

    // Data phase code for the operations that have one.
    function automatic logic [15:0] phase_code_of(input op_sel_t sel);
        logic [15:0] code;
        begin
            case (sel)
                SEL_DEVICE_INFO:  code = OPC_GET_DEVICE_INFO;
                SEL_STORAGE_IDS:  code = OPC_GET_STORAGE_IDS;
                SEL_STORAGE_INFO: code = OPC_GET_STORAGE_INFO;
                SEL_OBJ_HANDLES:  code = OPC_GET_OBJ_HANDLES;
                default:          code = 16'h0000;
            endcase
            return code;
        end
    endfunction

endpackage

### hdl/ptp_command_responder.sv
// Command responder for a picture transfer protocol device.
// The input stream carries one parsed command container per word: length,
// operation code, transaction id and first parameter in s_tdata, container
// type in s_tuser. The output stream carries result words: a data-phase
// marker (m_tuser high) that is always followed by a response word, or a
// response alone. m_tlast marks the response that ends a command.
// A command passes through a queue entry and then the output register, which
// takes it once the output is free. The output register issues one word per
// cycle while m_tready is high, and a command yields one word, or two when it
// has a data phase; a two-entry command queue lets the input keep taking words
// while the output stalls. When m_tready is low the current word holds and the
// queue fills; s_tready falls once both queue entries are taken.
// Reset (aresetn low, synchronous) closes the session, sets the expected
// transaction id to zero, restores the storage id register and empties the
// queue and the output register. cfg_wr_en writes the storage id register
// from cfg_wr_data; write it only while no command is in flight.
module ptp_command_responder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // container_length [31:0], op_code [47:32], transaction_id [79:48],
    // first_param [111:80]
    input  logic [ptpcr_pkg::IN_TDATA_W-1:0] s_tdata,
    // container_kind [15:0]
    input  logic [15:0] s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // phase_code [15:0], status [18:16], reply_transaction [50:19], zeros above
    output logic [ptpcr_pkg::OUT_TDATA_W-1:0] m_tdata,
    // is_data_phase [0]
    output logic        m_tuser,
    // last_of_run
    output logic        m_tlast
);
    import ptpcr_pkg::*;

    cmd_t        front_cmd;
    cmd_t        head_cmd;
    logic        q_full;
    logic        q_head_valid;
    logic        q_pop;
    logic [15:0] phase_code;
    logic [2:0]  status;
    logic [31:0] reply_tid;

    // Front end: header checks and opcode classification.
    ptpcr_front u_front (
        .container_length (s_tdata[31:0]),
        .container_kind   (s_tuser),
        .op_code          (s_tdata[47:32]),
        .transaction_id   (s_tdata[79:48]),
        .first_param      (s_tdata[111:80]),
        .cmd              (front_cmd)
    );

    assign s_tready = !q_full;

    // Queue of classified commands.
    ptpcr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_tvalid),
        .push_cmd   (front_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (head_cmd)
    );

    // Back end: session state and result words.
    ptpcr_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .head_valid     (q_head_valid),
        .head_cmd       (head_cmd),
        .pop            (q_pop),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_is_data    (m_tuser),
        .out_phase_code (phase_code),
        .out_status     (status),
        .out_reply_tid  (reply_tid),
        .out_last       (m_tlast)
    );

    assign m_tdata = {5'd0, reply_tid, status, phase_code};

    // A data-phase marker never ends a command.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> !m_tlast)
        else $error("data-phase marker flagged as last word");

    // A taken data-phase marker is followed at once by a success response.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser |=>
            m_tvalid && !m_tuser && m_tlast && status == ST_OK)
        else $error("data-phase marker not followed by success response");

    // The response after a data-phase marker repeats its transaction id.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser |=>
            m_tdata[OUT_TID_LSB +: 32] == $past(m_tdata[OUT_TID_LSB +: 32]))
        else $error("transaction id advanced inside a data phase");

    // The queue never takes a word while it is full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !s_tready)
        else $error("command queue accepted a word while full");

endmodule

### hdl/ptpcr_front.sv
module ptpcr_front (
    input  logic [31:0]   container_length,
    input  logic [15:0]   container_kind,
    input  logic [15:0]   op_code,
    input  logic [31:0]   transaction_id,
    input  logic [31:0]   first_param,
    output ptpcr_pkg::cmd_t cmd
);
    import ptpcr_pkg::*;

    logic    len_ok;
    logic    kind_ok;
    logic    class_ok;
    op_sel_t sel;

    // Header checks: the length must hold a whole number of parameter words,
    // from none up to the maximum parameter count.
    always_comb begin
        len_ok = (container_length >= HDR_BYTES) && (container_length <= MAX_LEN) &&
                 (container_length[1:0] == 2'b00);
        kind_ok = (container_kind == KIND_COMMAND) || (container_kind == KIND_DATA);
        class_ok = ((op_code & OP_CLASS_MASK) == OP_CLASS_CMD);
    end

    // Map the opcode onto the operation selector.
    always_comb begin
        case (op_code)
            OPC_GET_DEVICE_INFO:  sel = SEL_DEVICE_INFO;
            OPC_OPEN_SESSION:     sel = SEL_OPEN;
            OPC_CLOSE_SESSION:    sel = SEL_CLOSE;
            OPC_GET_STORAGE_IDS:  sel = SEL_STORAGE_IDS;
            OPC_GET_STORAGE_INFO: sel = SEL_STORAGE_INFO;
            OPC_GET_OBJ_HANDLES:  sel = SEL_OBJ_HANDLES;
            default:              sel = SEL_OTHER;
        endcase
    end

    assign cmd.fmt_ok = len_ok && kind_ok && class_ok;
    assign cmd.op_sel = sel;
    assign cmd.np_zero = (container_length == HDR_BYTES);
    assign cmd.np_one = (container_length == ONE_PARAM_LEN);
    assign cmd.tid = transaction_id;
    assign cmd.p0 = first_param;

endmodule

### hdl/ptpcr_queue.sv
module ptpcr_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  ptpcr_pkg::cmd_t push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output ptpcr_pkg::cmd_t head_cmd
);
    import ptpcr_pkg::*;

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && head_valid;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### hdl/ptpcr_back.sv
module ptpcr_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic [31:0]     cfg_wr_data,
    input  logic            head_valid,
    input  ptpcr_pkg::cmd_t head_cmd,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            out_is_data,
    output logic [15:0]     out_phase_code,
    output logic [2:0]      out_status,
    output logic [31:0]     out_reply_tid,
    output logic            out_last
);
    import ptpcr_pkg::*;

    logic [31:0] storage_id_reg;
    logic [31:0] session_reg;
    logic [31:0] session_next;
    logic [31:0] exp_tid_reg;
    logic [31:0] exp_tid_next;
    logic        pend_reg;
    logic        pend_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_is_data_reg;
    logic        out_is_data_next;
    logic [15:0] out_code_reg;
    logic [15:0] out_code_next;
    logic [2:0]  out_status_reg;
    logic [2:0]  out_status_next;
    logic [31:0] out_tid_reg;
    logic [31:0] out_tid_next;
    logic        out_last_reg;
    logic        out_last_next;

    logic        load_ok;
    logic        seq_ok;
    logic        sess_open;
    logic        has_data;
    logic        sess_set;
    logic        sess_clr;
    logic [2:0]  status;

    assign load_ok = !out_valid_reg || out_ready;
    assign seq_ok = (head_cmd.tid == exp_tid_reg);
    assign sess_open = (session_reg != '0);

    // Carry out the operation at the head of the queue against the session state.
    always_comb begin
        has_data = 1'b0;
        sess_set = 1'b0;
        sess_clr = 1'b0;
        status = ST_OK;
        if (!head_cmd.fmt_ok) begin
            status = ST_GENERAL;
        end else begin
            case (head_cmd.op_sel)
                SEL_DEVICE_INFO: begin
                    if (!head_cmd.np_zero || (head_cmd.tid != '0 && !seq_ok)) begin
                        status = ST_GENERAL;
                    end else begin
                        has_data = 1'b1;
                    end
                end
                SEL_OPEN: begin
                    if (!head_cmd.np_one) begin
                        status = ST_GENERAL;
                    end else if (head_cmd.p0 == '0) begin
                        status = ST_BAD_PARAM;
                    end else if (sess_open) begin
                        status = ST_ALREADY_OPEN;
                    end else begin
                        sess_set = 1'b1;
                    end
                end
                SEL_CLOSE: begin
                    if (!head_cmd.np_zero || !seq_ok) begin
                        status = ST_GENERAL;
                    end else if (!sess_open) begin
                        status = ST_NO_SESSION;
                    end else begin
                        sess_clr = 1'b1;
                    end
                end
                SEL_STORAGE_IDS, SEL_STORAGE_INFO, SEL_OBJ_HANDLES: begin
                    if (!seq_ok) begin
                        status = ST_GENERAL;
                    end else if (!sess_open) begin
                        status = ST_NO_SESSION;
                    end else if (head_cmd.op_sel == SEL_STORAGE_IDS && !head_cmd.np_zero) begin
                        status = ST_GENERAL;
                    end else if (head_cmd.op_sel == SEL_STORAGE_INFO && !head_cmd.np_one) begin
                        status = ST_GENERAL;
                    end else if (head_cmd.op_sel == SEL_STORAGE_INFO &&
                                 head_cmd.p0 != storage_id_reg) begin
                        status = ST_BAD_STORAGE;
                    end else if (head_cmd.op_sel == SEL_OBJ_HANDLES && head_cmd.np_zero) begin
                        status = ST_BAD_PARAM;
                    end else begin
                        has_data = 1'b1;
                    end
                end
                default: begin
                    status = ST_UNSUPPORTED;
                end
            endcase
        end
    end

    // Output register: a pending response goes first, then the next command.
    always_comb begin
        pop = 1'b0;
        pend_next = pend_reg;
        session_next = session_reg;
        exp_tid_next = exp_tid_reg;
        out_valid_next = out_valid_reg;
        out_is_data_next = out_is_data_reg;
        out_code_next = out_code_reg;
        out_status_next = out_status_reg;
        out_tid_next = out_tid_reg;
        out_last_next = out_last_reg;
        if (load_ok && pend_reg) begin
            // Success response that follows a data-phase marker.
            pend_next = 1'b0;
            out_valid_next = 1'b1;
            out_is_data_next = 1'b0;
            out_code_next = '0;
            out_status_next = ST_OK;
            out_tid_next = exp_tid_reg;
            out_last_next = 1'b1;
            exp_tid_next = exp_tid_reg + 32'd1;
        end else if (load_ok && head_valid) begin
            pop = 1'b1;
            out_valid_next = 1'b1;
            out_tid_next = exp_tid_reg;
            if (has_data) begin
                pend_next = 1'b1;
                out_is_data_next = 1'b1;
                out_code_next = phase_code_of(head_cmd.op_sel);
                out_status_next = ST_OK;
                out_last_next = 1'b0;
            end else begin
                out_is_data_next = 1'b0;
                out_code_next = '0;
                out_status_next = status;
                out_last_next = 1'b1;
                exp_tid_next = exp_tid_reg + 32'd1;
            end
            if (sess_set) begin
                session_next = head_cmd.p0;
            end else if (sess_clr) begin
                session_next = '0;
            end
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            storage_id_reg <= STORAGE_ID_RESET;
            session_reg <= '0;
            exp_tid_reg <= '0;
            pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                storage_id_reg <= cfg_wr_data;
            end
            session_reg <= session_next;
            exp_tid_reg <= exp_tid_next;
            pend_reg <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload needs no reset.
    always_ff @(posedge aclk) begin
        out_is_data_reg <= out_is_data_next;
        out_code_reg <= out_code_next;
        out_status_reg <= out_status_next;
        out_tid_reg <= out_tid_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_is_data = out_is_data_reg;
    assign out_phase_code = out_code_reg;
    assign out_status = out_status_reg;
    assign out_reply_tid = out_tid_reg;
    assign out_last = out_last_reg;

endmodule

### tb/tb_ptp_command_responder.sv
module tb_ptp_command_responder;

    import ptpcr_pkg::*;

    localparam int unsigned CLK_HALF = 4;
    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned REPORT_MAX = 10;

    // One result word as the block should present it.
    typedef struct packed {
        logic        is_marker;
        logic [15:0] code;
        logic [2:0]  status;
        logic [31:0] xact;
        logic        ends_cmd;
    } reply_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [31:0]           cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata;
    logic [15:0]           s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    // Responder state as the predictor tracks it.
    logic [31:0] storage_reg;
    logic [31:0] session_id;
    logic [31:0] next_xact;
    reply_t      expected_replies[$];

    // Traffic shaping shared by the sender, the receiver and the tests.
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_cycles;

    int unsigned cycle_count;
    int unsigned mismatch_count;
    int unsigned commands_sent;
    int unsigned words_checked;
    int unsigned markers_checked;
    int unsigned storage_writes;

    ptp_command_responder i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Run limit, so that a hung handshake cannot hold the simulation forever.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count >= LIMIT_CYCLES) begin
                $display("Timeout after %0d cycles, %0d result words still expected.",
                         cycle_count, expected_replies.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Result receiver: a counted hold-off wins over the random stall rate.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready = 1'b0;
                hold_cycles--;
            end else begin
                m_tready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Works out the result words of one accepted command and queues them.
    task automatic predict_command(input logic [31:0] len, input logic [15:0] kind,
                                   input logic [15:0] op, input logic [31:0] tid,
                                   input logic [31:0] p0);
        logic [31:0] nparams;
        logic        in_order;
        logic        with_data;
        logic [2:0]  st;
        begin
            nparams = (len - HDR_BYTES) >> 2;
            in_order = (tid == next_xact);
            with_data = 1'b0;
            st = ST_OK;
            if (len < HDR_BYTES || (kind != KIND_COMMAND && kind != KIND_DATA) ||
                (op & OP_CLASS_MASK) != OP_CLASS_CMD ||
                ((len - HDR_BYTES) & 32'd3) != 32'd0 || nparams > MAX_PARAMS) begin
                st = ST_GENERAL;
            end else begin
                case (op)
                    OPC_GET_DEVICE_INFO: begin
                        // A transaction id of zero is always welcome here.
                        if (nparams != 0 || (tid != 0 && !in_order))
                            st = ST_GENERAL;
                        else
                            with_data = 1'b1;
                    end
                    OPC_OPEN_SESSION: begin
                        if (nparams != 1)
                            st = ST_GENERAL;
                        else if (p0 == 0)
                            st = ST_BAD_PARAM;
                        else if (session_id != 0)
                            st = ST_ALREADY_OPEN;
                        else
                            session_id = p0;
                    end
                    OPC_CLOSE_SESSION: begin
                        if (nparams != 0 || !in_order)
                            st = ST_GENERAL;
                        else if (session_id == 0)
                            st = ST_NO_SESSION;
                        else
                            session_id = 0;
                    end
                    OPC_GET_STORAGE_IDS, OPC_GET_STORAGE_INFO, OPC_GET_OBJ_HANDLES: begin
                        if (!in_order)
                            st = ST_GENERAL;
                        else if (session_id == 0)
                            st = ST_NO_SESSION;
                        else if (op == OPC_GET_STORAGE_IDS && nparams != 0)
                            st = ST_GENERAL;
                        else if (op == OPC_GET_STORAGE_INFO && nparams != 1)
                            st = ST_GENERAL;
                        else if (op == OPC_GET_STORAGE_INFO && p0 != storage_reg)
                            st = ST_BAD_STORAGE;
                        else if (op == OPC_GET_OBJ_HANDLES && nparams < 1)
                            st = ST_BAD_PARAM;
                        else
                            with_data = 1'b1;
                    end
                    default: begin
                        st = ST_UNSUPPORTED;
                    end
                endcase
            end
            // The data marker carries the id but does not advance it.
            if (with_data)
                expected_replies.push_back('{1'b1, op, ST_OK, next_xact, 1'b0});
            expected_replies.push_back('{1'b0, 16'h0000, st, next_xact, 1'b1});
            next_xact = next_xact + 32'd1;
        end
    endtask

    // Offers one command word, waits for the handshake, then predicts.
    // Called and returning at a falling edge.
    task automatic send_command(input logic [31:0] len, input logic [15:0] kind,
                                input logic [15:0] op, input logic [31:0] tid,
                                input logic [31:0] p0);
        begin
            if ($urandom_range(99) < send_idle_pct) begin
                s_tvalid = 1'b0;
                do
                    @(negedge aclk);
                while ($urandom_range(99) < send_idle_pct);
            end
            s_tdata = {p0, tid, op, len};
            s_tuser = kind;
            s_tvalid = 1'b1;
            do
                @(posedge aclk);
            while (!s_tready);
            predict_command(len, kind, op, tid, p0);
            commands_sent++;
            @(negedge aclk);
        end
    endtask

    // Returns at a falling edge once every expected word has arrived.
    task automatic wait_drained();
        begin
            s_tvalid = 1'b0;
            while (expected_replies.size() != 0)
                @(posedge aclk);
            @(negedge aclk);
        end
    endtask

    // Storage id writes happen only with nothing in flight.
    task automatic write_storage_id(input logic [31:0] value);
        begin
            wait_drained();
            repeat (SETTLE_CYCLES) @(negedge aclk);
            cfg_wr_data = value;
            cfg_wr_en = 1'b1;
            @(negedge aclk);
            cfg_wr_en = 1'b0;
            storage_reg = value;
            storage_writes++;
        end
    endtask

    // Compares one accepted result word with the oldest expectation.
    task automatic check_reply();
        reply_t want;
        reply_t got;
        begin
            got = '{m_tuser, m_tdata[15:0], m_tdata[18:16],
                    m_tdata[OUT_TID_LSB+31:OUT_TID_LSB], m_tlast};
            if (expected_replies.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("Unexpected result word at cycle %0d: %p", cycle_count, got);
            end else begin
                want = expected_replies.pop_front();
                words_checked++;
                if (want.is_marker)
                    markers_checked++;
                if (got.is_marker !== want.is_marker || got.code !== want.code ||
                    got.status !== want.status || got.xact !== want.xact ||
                    got.ends_cmd !== want.ends_cmd) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("Result word mismatch at cycle %0d: expected %p, got %p",
                                 cycle_count, want, got);
                end
            end
        end
    endtask

    // Result monitor.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                check_reply();
        end
    end

    // Header checks: every way a container can fail before dispatch.
    task automatic test_header_checks();
        begin
            send_command(32'd0, KIND_COMMAND, OPC_GET_DEVICE_INFO, next_xact, 32'd0);
            send_command(32'hFFFF_FFFF, KIND_COMMAND, OPC_GET_DEVICE_INFO, next_xact, 32'd0);
            send_command(HDR_BYTES + 32'd1, KIND_COMMAND, OPC_GET_DEVICE_INFO, next_xact, 32'd0);
            send_command(MAX_LEN + 32'd4, KIND_COMMAND, OPC_GET_OBJ_HANDLES, next_xact, 32'd1);
            send_command(HDR_BYTES, 16'hFFFF, OPC_GET_DEVICE_INFO, next_xact, 32'd0);
            send_command(HDR_BYTES, KIND_COMMAND, 16'hFFFF, next_xact, 32'd0);
            // Bit 15 is outside the class mask, so this one reaches dispatch.
            send_command(HDR_BYTES, KIND_COMMAND, 16'h9001, next_xact, 32'd0);
            send_command(HDR_BYTES, KIND_COMMAND, 16'h1006, next_xact, 32'd0);
        end
    endtask

    // Each operation through its success path and through some of its error checks.
    task automatic test_session_commands();
        begin
            // A data-type container is served like a command.
            send_command(HDR_BYTES, KIND_DATA, OPC_GET_DEVICE_INFO, 32'd0, 32'd0);
            send_command(HDR_BYTES, KIND_COMMAND, OPC_GET_DEVICE_INFO, next_xact + 32'd5,
                         32'd0);
            send_command(HDR_BYTES, KIND_COMMAND, OPC_CLOSE_SESSION, next_xact, 32'd0);
            send_command(HDR_BYTES, KIND_COMMAND, OPC_GET_STORAGE_IDS, next_xact, 32'd0);
            send_command(ONE_PARAM_LEN, KIND_COMMAND, OPC_OPEN_SESSION, next_xact, 32'd0);
            send_command(ONE_PARAM_LEN, KIND_COMMAND, OPC_OPEN_SESSION, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF);
            send_command(ONE_PARAM_LEN, KIND_COMMAND, OPC_OPEN_SESSION, next_xact, 32'd1);
            send_command(ONE_PARAM_LEN, KIND_COMMAND, OPC_GET_STORAGE_IDS, next_xact, 32'd0);
            send_command(HDR_BYTES, KIND_COMMAND, OPC_GET_STORAGE_IDS, next_xact, 32'd0);
            send_command(ONE_PARAM_LEN, KIND_COMMAND, OPC_GET_STORAGE_INFO, next_xact,
                         storage_reg);
            send_command(ONE_PARAM_LEN, KIND_COMMAND, OPC_GET_STORAGE_INFO, next_xact,
                         ~storage_reg);
            send_command(HDR_BYTES, KIND_COMMAND, OPC_GET_STORAGE_INFO, next_xact,
                         storage_reg);
            send_command(HDR_BYTES, KIND_COMMAND, OPC_GET_OBJ_HANDLES, next_xact, 32'd0);
            send_command(MAX_LEN, KIND_COMMAND, OPC_GET_OBJ_HANDLES, next_xact, 32'd0);
            send_command(HDR_BYTES, KIND_COMMAND, OPC_CLOSE_SESSION, ~next_xact, 32'd0);
            send_command(HDR_BYTES, KIND_COMMAND, OPC_CLOSE_SESSION, next_xact, 32'd0);
        end
    endtask

    // Mostly well-formed commands that follow the session, with some noise.
    task automatic send_random_command();
        logic [31:0] len;
        logic [15:0] kind;
        logic [15:0] op;
        logic [31:0] tid;
        logic [31:0] p0;
        int unsigned nparams;
        int unsigned pick;
        begin
            if ($urandom_range(99) < 85) begin
                pick = $urandom_range(99);
                if (session_id == 0 && $urandom_range(99) < 40)
                    pick = 15;
                if (pick < 10) begin
                    op = OPC_GET_DEVICE_INFO;
                    nparams = 0;
                end else if (pick < 25) begin
                    op = OPC_OPEN_SESSION;
                    nparams = 1;
                end else if (pick < 32) begin
                    op = OPC_CLOSE_SESSION;
                    nparams = 0;
                end else if (pick < 52) begin
                    op = OPC_GET_STORAGE_IDS;
                    nparams = 0;
                end else if (pick < 72) begin
                    op = OPC_GET_STORAGE_INFO;
                    nparams = 1;
                end else if (pick < 92) begin
                    op = OPC_GET_OBJ_HANDLES;
                    nparams = $urandom_range(1, MAX_PARAMS);
                end else begin
                    op = OP_CLASS_CMD | 16'($urandom_range(12'hFFF));
                    nparams = $urandom_range(0, MAX_PARAMS);
                end
                if ($urandom_range(99) < 12)
                    nparams = $urandom_range(0, MAX_PARAMS);
                len = HDR_BYTES + 32'(4 * nparams);
                kind = ($urandom_range(9) == 0) ? KIND_DATA : KIND_COMMAND;
                if ($urandom_range(99) < 90)
                    tid = next_xact;
                else
                    tid = $urandom_range(1) ? 32'd0 : $urandom;
                if (op == OPC_GET_STORAGE_INFO && $urandom_range(99) < 80)
                    p0 = storage_reg;
                else if (op == OPC_OPEN_SESSION && $urandom_range(99) < 10)
                    p0 = 32'd0;
                else
                    p0 = $urandom;
            end else begin
                len = $urandom_range(1) ? $urandom : $urandom_range(MAX_LEN + 8);
                kind = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(3));
                op = $urandom_range(1) ? 16'($urandom) : 16'h1000 + 16'($urandom_range(15));
                tid = $urandom_range(1) ? $urandom : next_xact;
                p0 = $urandom;
            end
            send_command(len, kind, op, tid, p0);
        end
    endtask

    // Random traffic under one idle and stall mix.
    task automatic test_random_traffic(input int unsigned count, input int unsigned idle_pct,
                                       input int unsigned stall_pct);
        begin
            send_idle_pct = idle_pct;
            recv_stall_pct = stall_pct;
            repeat (count) send_random_command();
        end
    endtask

    // Output held off for a long stretch while commands keep coming, so the
    // queue fills and the input stalls; then a pause until all words drain.
    task automatic test_backpressure();
        begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
            hold_cycles = 80;
            repeat (12) send_random_command();
            wait_drained();
            repeat (12) send_random_command();
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 32'd0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        mismatch_count = 0;
        commands_sent = 0;
        words_checked = 0;
        markers_checked = 0;
        storage_writes = 0;
        storage_reg = STORAGE_ID_RESET;
        session_id = 32'd0;
        next_xact = 32'd0;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        test_header_checks();
        test_session_commands();
        write_storage_id(32'hFFFF_FFFF);
        test_random_traffic(400, 0, 0);
        write_storage_id(32'd0);
        test_random_traffic(400, 71, 0);
        write_storage_id($urandom);
        test_random_traffic(400, 0, 71);
        test_backpressure();
        write_storage_id(STORAGE_ID_RESET);
        test_random_traffic(430, 30, 30);

        // Let the last words come out, then a few quiet cycles.
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d commands and checked %0d result words, %0d of them data markers,",
                 commands_sent, words_checked, markers_checked);
        $display("over %0d storage id settings, four idle/stall mixes and a long hold-off.",
                 storage_writes + 1);
        if (mismatch_count == 0 && expected_replies.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d result words never arrived.",
                     mismatch_count, expected_replies.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### sim.f
hdl/ptpcr_pkg.sv
hdl/ptpcr_front.sv
hdl/ptpcr_queue.sv
hdl/ptpcr_back.sv
hdl/ptp_command_responder.sv
tb/tb_ptp_command_responder.sv
